// File: hdl/rolling_band_classifier_unit_macros.svh
// Assertion macros used by the rolling band classifier checker.
`ifndef ROLLING_BAND_CLASSIFIER_UNIT_MACROS_SVH
`define ROLLING_BAND_CLASSIFIER_UNIT_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define RBC_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rolling band classifier check failed");

// next-cycle implication, sampled on i_clk, off during reset
`define RBC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rolling band classifier check failed");

`endif

// File: hdl/rbc_pkg.sv
// Shared types and constants of the rolling band classifier.
package rbc_pkg;

    localparam int MAX_WINDOW = 256;
    localparam int PRICE_BITS = 24;
    localparam int SLOT_BITS  = $clog2(MAX_WINDOW);

    localparam logic [15:0] K_RESET   = 16'd8192;
    localparam logic [7:0]  WIN_RESET = 8'd19;

    localparam logic REG_BAND_K = 1'b0;
    localparam logic REG_WINDOW = 1'b1;

    localparam logic [1:0] POS_INSIDE = 2'd0;
    localparam logic [1:0] POS_ABOVE  = 2'd1;
    localparam logic [1:0] POS_BELOW  = 2'd2;

    localparam logic [6:0] STEPS_MEAN   = 7'd33;
    localparam logic [6:0] STEPS_VAR    = 7'd48;
    localparam logic [6:0] STEPS_EXCESS = 7'd25;
    localparam logic [4:0] SQRT_LAST    = 5'd23;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_A,
        OP_MUL_B,
        OP_FILL,
        OP_SPREAD,
        OP_DIV_MEAN,
        OP_TAKE_MEAN,
        OP_DIV_VAR,
        OP_TAKE_VAR,
        OP_SQRT,
        OP_KD,
        OP_BANDS,
        OP_CMP,
        OP_DIV_EXC,
        OP_TAKE_EXC,
        OP_RETIRE
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic div_busy;
        logic sqrt_last;
        logic need_exc;
        logic out_free;
    } t_status;

endpackage

// File: hdl/rbc_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module rbc_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_dividend,
    input  logic [23:0] i_divisor,
    input  logic [6:0]  i_steps,
    output logic        o_busy,
    output logic [63:0] o_quotient
);

    logic [23:0] r_rem;
    logic [63:0] r_num;
    logic [23:0] r_div;
    logic [6:0]  r_count;
    logic        r_busy;
    logic [24:0] n_shift;
    logic        n_ge;

    assign n_shift = {r_rem, r_num[63]};
    assign n_ge    = n_shift >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
        end else if (i_start) begin
            r_busy  <= 1'b1;
            r_count <= i_steps;
        end else if (r_busy) begin
            r_count <= r_count - 7'd1;
            if (r_count == 7'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= 24'(i_dividend >> i_steps);
            r_num <= i_dividend << (7'd64 - i_steps);
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? 24'(n_shift - {1'b0, r_div}) : n_shift[23:0];
            r_num <= {r_num[62:0], n_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_num;

endmodule

// File: hdl/rbc_ctrl.sv
// Sequencer of the rolling band classifier: steps the datapath through one request.
module rbc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    output rbc_pkg::t_cmd   o_cmd,
    input  rbc_pkg::t_status i_status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_FILL,
        S_MUL_B,
        S_SPREAD,
        S_MEAN,
        S_MEAN_W,
        S_VAR,
        S_VAR_W,
        S_SQRT,
        S_KD,
        S_BANDS,
        S_CMP,
        S_CLASS,
        S_EXC,
        S_EXC_W,
        S_OUT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd.op = rbc_pkg::OP_NONE;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = rbc_pkg::OP_LOAD;
                    n_state  = S_CHECK;
                end
            end
            S_CHECK: begin
                o_cmd.op = rbc_pkg::OP_MUL_A;
                n_state  = i_status.full ? S_MUL_B : S_FILL;
            end
            S_FILL: begin
                o_cmd.op = rbc_pkg::OP_FILL;
                n_state  = S_IDLE;
            end
            S_MUL_B: begin
                o_cmd.op = rbc_pkg::OP_MUL_B;
                n_state  = S_SPREAD;
            end
            S_SPREAD: begin
                o_cmd.op = rbc_pkg::OP_SPREAD;
                n_state  = S_MEAN;
            end
            S_MEAN: begin
                o_cmd.op = rbc_pkg::OP_DIV_MEAN;
                n_state  = S_MEAN_W;
            end
            S_MEAN_W: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = rbc_pkg::OP_TAKE_MEAN;
                    n_state  = S_VAR;
                end
            end
            S_VAR: begin
                o_cmd.op = rbc_pkg::OP_DIV_VAR;
                n_state  = S_VAR_W;
            end
            S_VAR_W: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = rbc_pkg::OP_TAKE_VAR;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = rbc_pkg::OP_SQRT;
                if (i_status.sqrt_last) begin
                    n_state = S_KD;
                end
            end
            S_KD: begin
                o_cmd.op = rbc_pkg::OP_KD;
                n_state  = S_BANDS;
            end
            S_BANDS: begin
                o_cmd.op = rbc_pkg::OP_BANDS;
                n_state  = S_CMP;
            end
            S_CMP: begin
                o_cmd.op = rbc_pkg::OP_CMP;
                n_state  = S_CLASS;
            end
            S_CLASS: begin
                n_state = S_EXC;
            end
            S_EXC: begin
                if (i_status.need_exc) begin
                    o_cmd.op = rbc_pkg::OP_DIV_EXC;
                    n_state  = S_EXC_W;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_EXC_W: begin
                if (!i_status.div_busy) begin
                    o_cmd.op = rbc_pkg::OP_TAKE_EXC;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.op = rbc_pkg::OP_RETIRE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = r_state != S_IDLE;

endmodule

// File: hdl/rbc_dp.sv
// Datapath of the rolling band classifier: price ring, running sums and band arithmetic.
module rbc_dp (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  rbc_pkg::t_cmd         i_cmd,
    output rbc_pkg::t_status      o_status,
    input  logic [23:0]           i_price,
    input  logic [15:0]           i_band_width_k,
    input  logic [7:0]            i_window_minus_one,
    input  logic                  i_window_clear,
    input  logic                  i_stall,
    output logic                  o_valid,
    output logic [23:0]           o_window_mean,
    output logic [23:0]           o_window_deviation,
    output logic [24:0]           o_upper_band,
    output logic signed [24:0]    o_lower_band,
    output logic [1:0]            o_position,
    output logic [7:0]            o_excess_units
);

    logic [23:0] r_ring [rbc_pkg::MAX_WINDOW];

    logic [31:0] r_s1;
    logic [55:0] r_s2;
    logic [8:0]  r_fill;
    logic [7:0]  r_slot;
    logic [23:0] r_price;
    logic [23:0] r_old;
    logic [36:0] r_t1;
    logic [36:0] r_t2;
    logic [63:0] r_sq;
    logic [16:0] r_ww;
    logic [47:0] r_pp;
    logic [47:0] r_oo;
    logic [63:0] r_spread;
    logic [23:0] r_mean;
    logic [47:0] r_v;
    logic [47:0] r_root;
    logic [47:0] r_bit;
    logic [4:0]  r_sqcnt;
    logic [23:0] r_dev;
    logic [27:0] r_kd;
    logic [24:0] r_upper;
    logic signed [24:0] r_lower;
    logic [1:0]  r_pos;
    logic [23:0] r_d;
    logic [7:0]  r_exc;
    logic        r_out_valid;

    logic [8:0]  n_win;
    logic [7:0]  n_slot;
    logic        n_start;
    logic [63:0] n_dividend;
    logic [23:0] n_divisor;
    logic [6:0]  n_steps;
    logic        w_busy;
    logic [63:0] w_quo;
    logic [47:0] n_trial;
    logic [39:0] n_kprod;
    logic [28:0] n_usum;
    logic signed [29:0] n_ldiff;
    logic        n_out_free;

    assign n_win      = {1'b0, i_window_minus_one} + 9'd1;
    assign n_slot     = ({1'b0, r_slot} + 9'd1 >= n_win) ? 8'd0 : r_slot + 8'd1;
    assign n_trial    = r_root + r_bit;
    assign n_kprod    = 40'(i_band_width_k) * 40'(r_dev) + 40'd2048;
    assign n_usum     = 29'(r_mean) + 29'(r_kd);
    assign n_ldiff    = $signed({6'd0, r_mean}) - $signed({2'd0, r_kd});
    assign n_out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_start    = 1'b0;
        n_dividend = 64'(r_s1) + 64'(n_win >> 1);
        n_divisor  = 24'(n_win);
        n_steps    = rbc_pkg::STEPS_MEAN;
        case (i_cmd.op)
            rbc_pkg::OP_DIV_MEAN: begin
                n_start = 1'b1;
            end
            rbc_pkg::OP_DIV_VAR: begin
                n_start    = 1'b1;
                n_dividend = r_spread;
                n_divisor  = 24'(r_ww);
                n_steps    = rbc_pkg::STEPS_VAR;
            end
            rbc_pkg::OP_DIV_EXC: begin
                n_start    = 1'b1;
                n_dividend = 64'(r_d) + 64'(r_dev) - 64'd1;
                n_divisor  = r_dev;
                n_steps    = rbc_pkg::STEPS_EXCESS;
            end
            default: begin
                n_start = 1'b0;
            end
        endcase
    end

    rbc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (n_start),
        .i_dividend (n_dividend),
        .i_divisor  (n_divisor),
        .i_steps    (n_steps),
        .o_busy     (w_busy),
        .o_quotient (w_quo)
    );

    // ring memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rbc_pkg::OP_LOAD) begin
            r_old <= r_ring[r_slot];
        end
        if (i_cmd.op == rbc_pkg::OP_FILL || i_cmd.op == rbc_pkg::OP_RETIRE) begin
            r_ring[r_slot] <= r_price;
        end
    end

    // window bookkeeping and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1        <= '0;
            r_s2        <= '0;
            r_fill      <= '0;
            r_slot      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_window_clear) begin
                r_s1   <= '0;
                r_s2   <= '0;
                r_fill <= '0;
                r_slot <= '0;
            end else if (i_cmd.op == rbc_pkg::OP_FILL) begin
                r_s1   <= r_s1 + 32'(r_price);
                r_s2   <= r_s2 + 56'(r_pp);
                r_fill <= r_fill + 9'd1;
                r_slot <= n_slot;
            end else if (i_cmd.op == rbc_pkg::OP_RETIRE) begin
                r_s1        <= r_s1 - 32'(r_old) + 32'(r_price);
                r_s2        <= r_s2 - 56'(r_oo) + 56'(r_pp);
                r_slot      <= n_slot;
                r_out_valid <= 1'b1;
            end
        end
    end

    // arithmetic
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            rbc_pkg::OP_LOAD: begin
                r_price <= i_price;
            end
            rbc_pkg::OP_MUL_A: begin
                r_t1 <= 37'(n_win) * 37'(r_s2[27:0]);
                r_sq <= 64'(r_s1) * 64'(r_s1);
                r_ww <= 17'(n_win) * 17'(n_win);
                r_pp <= 48'(r_price) * 48'(r_price);
            end
            rbc_pkg::OP_MUL_B: begin
                r_t2 <= 37'(n_win) * 37'(r_s2[55:28]);
                r_oo <= 48'(r_old) * 48'(r_old);
            end
            rbc_pkg::OP_SPREAD: begin
                r_spread <= 64'({r_t2, 28'd0}) + 64'(r_t1) - r_sq;
            end
            rbc_pkg::OP_TAKE_MEAN: begin
                r_mean <= w_quo[23:0];
            end
            rbc_pkg::OP_TAKE_VAR: begin
                r_v     <= w_quo[47:0];
                r_root  <= '0;
                r_bit   <= 48'd1 << 46;
                r_sqcnt <= '0;
            end
            rbc_pkg::OP_SQRT: begin
                if (r_v >= n_trial) begin
                    r_v    <= r_v - n_trial;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit   <= r_bit >> 2;
                r_sqcnt <= r_sqcnt + 5'd1;
            end
            rbc_pkg::OP_KD: begin
                r_dev <= r_root[23:0];
            end
            rbc_pkg::OP_BANDS: begin
                r_kd <= n_kprod[39:12];
            end
            rbc_pkg::OP_CMP: begin
                r_upper <= (n_usum > 29'h1FFFFFF) ? 25'h1FFFFFF : n_usum[24:0];
                r_lower <= (n_ldiff < -30'sd16777216) ? -25'sd16777216 : n_ldiff[24:0];
            end
            default: begin
            end
        endcase
    end

    // classify against the bands in the cycle after they settle
    logic r_cmp_pend;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_pend <= 1'b0;
        end else begin
            r_cmp_pend <= i_cmd.op == rbc_pkg::OP_CMP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_cmp_pend) begin
            if ({1'b0, r_price} > r_upper) begin
                r_pos <= rbc_pkg::POS_ABOVE;
                r_exc <= 8'd255;
            end else if ($signed({1'b0, r_price}) < r_lower) begin
                r_pos <= rbc_pkg::POS_BELOW;
                r_exc <= 8'd0;
            end else begin
                r_pos <= rbc_pkg::POS_INSIDE;
                r_exc <= 8'd0;
            end
            r_d <= r_price - r_upper[23:0];
        end else if (i_cmd.op == rbc_pkg::OP_TAKE_EXC) begin
            r_exc <= (w_quo > 64'd255) ? 8'd255 : w_quo[7:0];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == rbc_pkg::OP_RETIRE) begin
            o_window_mean      <= r_mean;
            o_window_deviation <= r_dev;
            o_upper_band       <= r_upper;
            o_lower_band       <= r_lower;
            o_position         <= r_pos;
            o_excess_units     <= r_exc;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_status.full      = r_fill >= n_win;
    assign o_status.div_busy  = w_busy || n_start;
    assign o_status.sqrt_last = r_sqcnt == rbc_pkg::SQRT_LAST;
    assign o_status.need_exc  = r_pos == rbc_pkg::POS_ABOVE && r_dev != 24'd0;
    assign o_status.out_free  = n_out_free;

endmodule

// File: hdl/rolling_band_classifier_unit.sv
// Top level of the rolling band classifier: register port, sequencer and datapath.
// One price request at a time. While the window is filling a price is stored in the
// load, check and fill steps and gives no result, and the next price is taken once
// the sequencer is idle again. Once the window is full a price passes every step,
// adding an excess division when it lies above the upper band and the deviation is
// not zero, and the next price can be taken as its result is offered; most of the
// work is the shared one-bit-per-cycle divider (33 steps for the mean, 48 for the
// variance, 25 for the excess) and the 24-step square root. A finished result waits
// in the output register while the next price is worked on; if it is still stalled
// when the next one is ready, the block holds the new result and takes no price
// until the output register is free. A write to window_minus_one empties the window.
module rolling_band_classifier_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [23:0]        i_price,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [23:0]        o_window_mean,
    output logic [23:0]        o_window_deviation,
    output logic [24:0]        o_upper_band,
    output logic signed [24:0] o_lower_band,
    output logic [1:0]         o_position,
    output logic [7:0]         o_excess_units
);

    logic [15:0] r_band_k;
    logic [7:0]  r_win_m1;
    logic        n_wr;
    logic        n_clear;

    rbc_pkg::t_cmd    w_cmd;
    rbc_pkg::t_status w_status;

    assign n_wr    = psel && penable && pwrite;
    assign n_clear = n_wr && paddr[2] == rbc_pkg::REG_WINDOW;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_k <= rbc_pkg::K_RESET;
            r_win_m1 <= rbc_pkg::WIN_RESET;
        end else if (n_wr) begin
            if (paddr[2] == rbc_pkg::REG_BAND_K) begin
                r_band_k <= pwdata[15:0];
            end else begin
                r_win_m1 <= pwdata[7:0];
            end
        end
    end

    assign prdata = (paddr[2] == rbc_pkg::REG_BAND_K) ? {16'd0, r_band_k} : {24'd0, r_win_m1};

    rbc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_cmd    (w_cmd),
        .i_status (w_status)
    );

    rbc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_status           (w_status),
        .i_price            (i_price),
        .i_band_width_k     (r_band_k),
        .i_window_minus_one (r_win_m1),
        .i_window_clear     (n_clear),
        .i_stall            (i_stall),
        .o_valid            (o_valid),
        .o_window_mean      (o_window_mean),
        .o_window_deviation (o_window_deviation),
        .o_upper_band       (o_upper_band),
        .o_lower_band       (o_lower_band),
        .o_position         (o_position),
        .o_excess_units     (o_excess_units)
    );

endmodule

// File: hdl/rbc_checker.sv
// Port-level checks of the rolling band classifier and their binding.
`include "rolling_band_classifier_unit_macros.svh"

module rbc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_valid,
    input logic               i_stall,
    input logic [23:0]        o_window_mean,
    input logic [23:0]        o_window_deviation,
    input logic [24:0]        o_upper_band,
    input logic [1:0]         o_position,
    input logic [7:0]         o_excess_units
);

    logic w_above;

    assign w_above = o_valid && o_position == rbc_pkg::POS_ABOVE;

    `RBC_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_window_mean))
    `RBC_ASSERT_NOW(a_pos_code, o_valid, o_position <= rbc_pkg::POS_BELOW)
    `RBC_ASSERT_NOW(a_excess_zero, o_valid && !w_above, o_excess_units == 8'd0)
    `RBC_ASSERT_NOW(a_flat_max, w_above && o_window_deviation == 24'd0, o_excess_units == 8'd255)
    `RBC_ASSERT_NOW(a_upper_ge_mean, o_valid, o_upper_band >= {1'b0, o_window_mean})

endmodule

bind rolling_band_classifier_unit rbc_checker u_rbc_checker (.*);

// File: verif/testbench.sv
// Self-checking testbench for the rolling band classifier unit.
`timescale 1ns / 1ps

module testbench;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 200;

    typedef struct packed {
        logic [23:0]        mean;
        logic [23:0]        deviation;
        logic [24:0]        upper;
        logic signed [24:0] lower;
        logic [1:0]         position;
        logic [7:0]         excess;
    } t_band_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               i_valid;
    logic               o_stall;
    logic [23:0]        i_price;
    logic               o_valid;
    logic               i_stall;
    logic [23:0]        o_window_mean;
    logic [23:0]        o_window_deviation;
    logic [24:0]        o_upper_band;
    logic signed [24:0] o_lower_band;
    logic [1:0]         o_position;
    logic [7:0]         o_excess_units;

    // predictor state
    logic [23:0]     ring_prices [rbc_pkg::MAX_WINDOW];
    logic [31:0]     price_total;
    logic [55:0]     square_total;
    int unsigned     held_count;
    int unsigned     next_slot;
    logic [15:0]     k_setting;
    logic [7:0]      window_setting;

    t_band_result    expected_bands [$];
    int              error_count;
    int              result_count;
    int              price_count;
    int              position_seen [3];
    int              send_idle_pct;
    int              stall_pct;
    int              quiet_cycles;

    rolling_band_classifier_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic int unsigned window_length();
        int unsigned w;
        w = window_setting + 1;
        if (w > rbc_pkg::MAX_WINDOW) w = rbc_pkg::MAX_WINDOW;
        return w;
    endfunction

    function automatic void clear_window();
        price_total  = '0;
        square_total = '0;
        held_count   = 0;
        next_slot    = 0;
    endfunction

    function automatic void predict_bands(logic [23:0] p);
        longint unsigned s1, s2, wl, mean, spread, dev, kd, upper, d, excess, old;
        longint          lower;
        logic [1:0]      pos;
        t_band_result    r;
        int unsigned     w;
        w = window_length();
        if (next_slot >= rbc_pkg::MAX_WINDOW) next_slot = 0;
        if (held_count >= w) begin
            s1 = price_total;
            s2 = square_total;
            wl = w;
            mean = (s1 + wl / 2) / wl;
            spread = wl * s2 - s1 * s1;
            dev = root_floor(spread / (wl * wl));
            kd = (longint'(k_setting) * dev + 2048) >> 12;
            upper = mean + kd;
            if (upper > 64'h1FF_FFFF) upper = 64'h1FF_FFFF;
            lower = longint'(mean) - longint'(kd);
            if (lower < -16777216) lower = -16777216;
            pos = rbc_pkg::POS_INSIDE;
            excess = 0;
            if (longint'(p) > longint'(upper)) begin
                pos = rbc_pkg::POS_ABOVE;
                d = p - upper;
                if (dev == 0) excess = 255;
                else begin
                    excess = (d + dev - 1) / dev;
                    if (excess > 255) excess = 255;
                end
            end else if (longint'(p) < lower) begin
                pos = rbc_pkg::POS_BELOW;
            end
            r.mean      = mean[23:0];
            r.deviation = dev[23:0];
            r.upper     = upper[24:0];
            r.lower     = lower[24:0];
            r.position  = pos;
            r.excess    = excess[7:0];
            expected_bands = {expected_bands, r};
            old = ring_prices[next_slot];
            price_total  = 32'(s1 - old + p);
            square_total = 56'(s2 - old * old + longint'(p) * p);
        end else begin
            price_total  = price_total + p;
            square_total = 56'(square_total + longint'(p) * p);
            held_count++;
        end
        ring_prices[next_slot] = p;
        next_slot++;
        if (next_slot >= w) next_slot = 0;
    endfunction

    task automatic send_price(logic [23:0] p);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct) gap++;
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_price <= p;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_bands(p);
        price_count++;
    endtask

    task automatic end_burst();
        i_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        while (expected_bands.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'(4 * rbc_pkg::REG_BAND_K)) k_setting = value[15:0];
        else if (addr == 3'(4 * rbc_pkg::REG_WINDOW)) begin
            window_setting = value[7:0];
            clear_window();
        end
    endtask

    task automatic configure(logic [15:0] k, logic [7:0] wmo);
        wait_idle();
        write_register(3'(4 * rbc_pkg::REG_BAND_K), {16'd0, k});
        write_register(3'(4 * rbc_pkg::REG_WINDOW), {24'd0, wmo});
    endtask

    function automatic logic [23:0] market_price(logic [23:0] base);
        int noise;
        case ($urandom_range(9))
            0: return 24'($urandom);
            1: return base + 24'($urandom_range(4000));
            2: return (base > 24'd4000) ? base - 24'($urandom_range(4000)) : 24'd0;
            default: begin
                noise = int'($urandom_range(400)) - 200;
                return 24'(int'(base) + noise);
            end
        endcase
    endfunction

    task automatic test_default_window();
        logic [23:0] base;
        base = 24'h10_0000;
        for (int i = 0; i < 20; i++) send_price(base + 24'($urandom_range(255)));
        send_price(24'hFF_FFFF);
        send_price(24'h00_0000);
        send_price(base);
        end_burst();
    endtask

    task automatic test_window_of_one();
        configure(16'hFFFF, 8'd0);
        send_price(24'h00_0000);
        send_price(24'hFF_FFFF);
        send_price(24'hFF_FFFF);
        send_price(24'h00_0000);
        send_price(24'h00_0005);
        end_burst();
    endtask

    task automatic test_band_width_extremes();
        configure(16'h0000, 8'd1);
        for (int i = 0; i < 6; i++) send_price(i[0] ? 24'hFF_FFFF : 24'h00_0000);
        end_burst();
        configure(16'hFFFF, 8'd1);
        for (int i = 0; i < 6; i++) send_price(i[0] ? 24'hFF_FFFF : 24'h00_0000);
        send_price(24'h80_0000);
        end_burst();
    endtask

    task automatic test_longest_window();
        logic [23:0] base;
        configure(16'd8192, 8'd255);
        base = 24'($urandom);
        for (int i = 0; i < 256; i++) send_price(24'hFF_FFFF - 24'($urandom_range(3)));
        for (int i = 0; i < 12; i++) send_price(market_price(base));
        end_burst();
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_level, int items);
        logic [23:0] base;
        int sent;
        sent = 0;
        while (sent < items) begin
            wait_idle();
            send_idle_pct = idle_pct;
            stall_pct = stall_level;
            configure(16'($urandom), ($urandom_range(9) == 0) ? 8'($urandom)
                                                              : 8'($urandom_range(15)));
            base = 24'($urandom);
            for (int i = 0; i < 60; i++) begin
                send_price(market_price(base));
                if ($urandom_range(3) == 0) base = market_price(base);
                sent++;
            end
            end_burst();
        end
        wait_idle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    always @(posedge i_clk) begin
        t_band_result exp_r;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
            if (o_valid && !i_stall) begin
                result_count++;
                if (expected_bands.size() == 0) begin
                    error_count++;
                    $display("%0t unexpected result mean %h", $realtime, o_window_mean);
                end else begin
                    exp_r = expected_bands.pop_front();
                    if (o_position <= rbc_pkg::POS_BELOW) position_seen[o_position]++;
                    if ({o_window_mean, o_window_deviation, o_upper_band, o_lower_band,
                         o_position, o_excess_units} !== exp_r) begin
                        error_count++;
                        $display("%0t mean exp %h got %h", $realtime, exp_r.mean,
                                 o_window_mean);
                        $display("%0t deviation exp %h got %h", $realtime, exp_r.deviation,
                                 o_window_deviation);
                        $display("%0t upper exp %h got %h", $realtime, exp_r.upper,
                                 o_upper_band);
                        $display("%0t lower exp %h got %h", $realtime, exp_r.lower,
                                 o_lower_band);
                        $display("%0t position exp %0d got %0d", $realtime, exp_r.position,
                                 o_position);
                        $display("%0t excess exp %0d got %0d", $realtime, exp_r.excess,
                                 o_excess_units);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        i_rst_n <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        i_valid <= 1'b0;
        i_price <= '0;
        error_count   = 0;
        result_count  = 0;
        price_count   = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        position_seen = '{0, 0, 0};
        k_setting      = rbc_pkg::K_RESET;
        window_setting = rbc_pkg::WIN_RESET;
        clear_window();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_default_window();
        test_window_of_one();
        test_band_width_extremes();
        test_longest_window();
        test_random_traffic(0, 0, 240);
        test_random_traffic(51, 0, 240);
        test_random_traffic(0, 51, 240);
        test_random_traffic(19, 19, 240);
        wait_idle();

        $display("Sent %0d prices, checked %0d results", price_count, result_count);
        $display("Positions inside/above/below: %0d/%0d/%0d",
                 position_seen[0], position_seen[1], position_seen[2]);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/rbc_pkg.sv
hdl/rbc_div.sv
hdl/rbc_ctrl.sv
hdl/rbc_dp.sv
hdl/rolling_band_classifier_unit.sv
hdl/rbc_checker.sv
verif/testbench.sv
